>>> rtl/mer_pkg.sv
// Package for the midpoint ellipse rasteriser.
// Holds the default coordinate width, the point beats per step and the sequencer state type.
// No dependencies.
package mer_pkg;

   localparam int COORD_BITS_DEF = 10;
   localparam int BEATS_PER_STEP = 4;

   typedef enum logic [13:0] {
      ST_IDLE   = 14'b00000000000001,
      ST_RX     = 14'b00000000000010,
      ST_RY     = 14'b00000000000100,
      ST_RXRY   = 14'b00000000001000,
      ST_INIT   = 14'b00000000010000,
      ST_P1     = 14'b00000000100000,
      ST_P2     = 14'b00000001000000,
      ST_UPD    = 14'b00000010000000,
      ST_R2_A   = 14'b00000100000000,
      ST_R2_B   = 14'b00001000000000,
      ST_R2_C   = 14'b00010000000000,
      ST_R2_D   = 14'b00100000000000,
      ST_R2_E   = 14'b01000000000000,
      ST_R2_F   = 14'b10000000000000
   } mer_state_type;

endpackage

>>> rtl/midpoint_ellipse_rasterizer.sv
// Midpoint ellipse rasteriser, top level.
// Depends on mer_pkg (state type, default coordinate width, beats per step).
//
// A start beat (opcode 0) latches centre and radii and sets up the decision value
// through states RX, RY, RXRY and INIT. A step beat (opcode 1) on an active figure
// advances the walker through P1, P2 and UPD, and also through R2_A to R2_F on the step
// that crosses from region 1 to region 2, then hands out its four symmetric points as
// four result beats, the fourth with step_last and, on the final step, figure_done.
// All products go through one registered signed multiplier of 2*COORD_BITS+5 bits per
// operand. A step on an idle block is taken and gives no beats.
module midpoint_ellipse_rasterizer
   import mer_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_opcode,
   input  logic [COORD_BITS-1:0]        req_center_x,
   input  logic [COORD_BITS-1:0]        req_center_y,
   input  logic [COORD_BITS-1:0]        req_radius_x,
   input  logic [COORD_BITS-1:0]        req_radius_y,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [COORD_BITS+1:0] rsp_point_x,
   output logic signed [COORD_BITS+1:0] rsp_point_y,
   output logic                         rsp_step_last,
   output logic                         rsp_figure_done
);

   localparam int CW = COORD_BITS + 2;       // position / point width
   localparam int SW = 2 * COORD_BITS;       // squared radius width
   localparam int MW = 2 * COORD_BITS + 5;   // multiplier operand width
   localparam int DW = 4 * COORD_BITS + 8;   // decision width
   localparam int BW = $clog2(BEATS_PER_STEP) + 1;
   localparam logic [BW-1:0] LAST_BEAT = BW'(BEATS_PER_STEP);
   localparam logic signed [CW-1:0] ONE_C = CW'(1);
   localparam logic signed [CW:0]   ONE_W = (CW + 1)'(1);

   mer_state_type            state_ff, state_in;
   logic                     active_ff, active_in;
   logic                     reg2_ff, reg2_in;
   logic                     br_ff, br_in;
   logic signed [CW-1:0]     x_ff, x_in, y_ff, y_in;
   logic signed [CW-1:0]     ox_ff, ox_in, oy_ff, oy_in;
   logic [COORD_BITS-1:0]    cx_ff, cx_in, cy_ff, cy_in, rad_ff, rad_in;
   logic [SW-1:0]            rx2_ff, rx2_in, ry2_ff, ry2_in;
   logic signed [DW-1:0]     d_ff, d_in, p1_ff, p1_in, acc_ff, acc_in, prod_ff, prod_in;
   logic [BW-1:0]            beat_ff, beat_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [CW-1:0]     px_ff, px_in, py_ff, py_in;
   logic                     last_ff, last_in, done_ff, done_in;

   logic signed [MW-1:0]     mul_a, mul_b;
   logic signed [2*MW-1:0]   mul_p;
   logic signed [DW-1:0]     rx2_w, ry2_w, delta;
   logic signed [CW:0]       a_w, b_w;
   logic [BW-2:0]            idx;
   logic                     take, load, stay, emit;

   assign req_stall = (state_ff != ST_IDLE) || (beat_ff != '0);
   assign take      = req_valid && !req_stall;
   assign emit      = state_ff == ST_IDLE && beat_ff != '0;
   assign load      = emit && (!rsp_valid_ff || !rsp_stall);
   assign idx       = beat_ff[BW-2:0] - (BW - 1)'(1);

   assign rx2_w = DW'(rx2_ff);
   assign ry2_w = DW'(ry2_ff);
   assign a_w   = {x_ff, 1'b1};
   assign b_w   = (CW + 1)'(y_ff) - ONE_W;
   assign mul_p = mul_a * mul_b;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_RX: begin
            mul_a = MW'(rad_ff);
            mul_b = MW'(rad_ff);
         end
         ST_RY: begin
            mul_a = MW'(y_ff);
            mul_b = MW'(y_ff);
         end
         ST_RXRY: begin
            mul_a = MW'(rx2_ff);
            mul_b = MW'(y_ff);
         end
         ST_P1: begin
            mul_a = MW'(ry2_ff);
            mul_b = MW'(x_ff);
         end
         ST_P2: begin
            mul_a = MW'(rx2_ff);
            mul_b = MW'(y_ff);
         end
         ST_R2_A: begin
            mul_a = MW'(a_w);
            mul_b = MW'(a_w);
         end
         ST_R2_B: begin
            mul_a = MW'(ry2_ff);
            mul_b = prod_ff[MW-1:0];
         end
         ST_R2_C: begin
            mul_a = MW'(b_w);
            mul_b = MW'(b_w);
         end
         ST_R2_D: begin
            mul_a = MW'(rx2_ff);
            mul_b = prod_ff[MW-1:0];
         end
         ST_R2_E: begin
            mul_a = MW'(rx2_ff);
            mul_b = MW'(ry2_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // decision update after one advance; prod_ff holds rx2*y, p1_ff holds ry2*x
   always_comb begin
      delta = '0;
      if (!reg2_ff || !br_ff) begin
         delta = delta + (p1_ff <<< 3);
      end
      if (reg2_ff || br_ff) begin
         delta = delta - (prod_ff <<< 3);
      end
      if (!reg2_ff) begin
         delta = delta + (ry2_w <<< 2);
      end else if (br_ff) begin
         delta = delta - (rx2_w <<< 2);
      end else begin
         delta = delta + (rx2_w <<< 2);
      end
   end

   assign stay = !y_ff[CW-1] && (p1_ff <= prod_ff);

   always_comb begin
      state_in     = state_ff;
      active_in    = active_ff;
      reg2_in      = reg2_ff;
      br_in        = br_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      ox_in        = ox_ff;
      oy_in        = oy_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      rad_in       = rad_ff;
      rx2_in       = rx2_ff;
      ry2_in       = ry2_ff;
      d_in         = d_ff;
      p1_in        = p1_ff;
      acc_in       = acc_ff;
      prod_in      = mul_p[DW-1:0];
      beat_in      = beat_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      px_in        = px_ff;
      py_in        = py_ff;
      last_in      = last_ff;
      done_in      = done_ff;

      if (load) begin
         rsp_valid_in = 1'b1;
         px_in   = idx[0] ? CW'(cx_ff) - ox_ff : CW'(cx_ff) + ox_ff;
         py_in   = idx[1] ? CW'(cy_ff) - oy_ff : CW'(cy_ff) + oy_ff;
         last_in = beat_ff == LAST_BEAT;
         done_in = beat_ff == LAST_BEAT && !active_ff;
         beat_in = beat_ff + BW'(1);
      end

      case (state_ff)
         ST_IDLE: begin
            if (take) begin
               if (!req_opcode) begin
                  cx_in     = req_center_x;
                  cy_in     = req_center_y;
                  rad_in    = req_radius_x;
                  x_in      = '0;
                  y_in      = CW'(req_radius_y);
                  reg2_in   = 1'b0;
                  active_in = 1'b0;
                  state_in  = ST_RX;
               end else if (active_ff) begin
                  ox_in = x_ff;
                  oy_in = y_ff;
                  if (!reg2_ff) begin
                     br_in = !d_ff[DW-1];
                     x_in  = x_ff + ONE_C;
                     if (!d_ff[DW-1]) begin
                        y_in = y_ff - ONE_C;
                     end
                  end else begin
                     br_in = d_ff > 0;
                     y_in  = y_ff - ONE_C;
                     if (!(d_ff > 0)) begin
                        x_in = x_ff + ONE_C;
                     end
                  end
                  state_in = ST_P1;
               end
            end
         end
         ST_RX:   state_in = ST_RY;
         ST_RY: begin
            rx2_in   = prod_ff[SW-1:0];
            state_in = ST_RXRY;
         end
         ST_RXRY: begin
            ry2_in   = prod_ff[SW-1:0];
            state_in = ST_INIT;
         end
         ST_INIT: begin
            d_in      = (ry2_w <<< 2) - (prod_ff <<< 2) + rx2_w;
            active_in = 1'b1;
            state_in  = ST_IDLE;
         end
         ST_P1:   state_in = ST_P2;
         ST_P2: begin
            p1_in    = prod_ff;
            state_in = ST_UPD;
         end
         ST_UPD: begin
            d_in = d_ff + delta;
            if (reg2_ff) begin
               active_in = !y_ff[CW-1];
               beat_in   = BW'(1);
               state_in  = ST_IDLE;
            end else if (stay) begin
               beat_in  = BW'(1);
               state_in = ST_IDLE;
            end else begin
               reg2_in  = 1'b1;
               state_in = ST_R2_A;
            end
         end
         ST_R2_A: state_in = ST_R2_B;
         ST_R2_B: state_in = ST_R2_C;
         ST_R2_C: begin
            acc_in   = prod_ff;
            state_in = ST_R2_D;
         end
         ST_R2_D: state_in = ST_R2_E;
         ST_R2_E: begin
            acc_in   = acc_ff + (prod_ff <<< 2);
            state_in = ST_R2_F;
         end
         ST_R2_F: begin
            d_in      = acc_ff - (prod_ff <<< 2);
            active_in = !y_ff[CW-1];
            beat_in   = BW'(1);
            state_in  = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase

      // beat counter wraps to zero after the fourth point
      if (load && beat_ff == LAST_BEAT) begin
         beat_in = '0;
      end
   end

   // beat_ff: 0 = nothing to send, 1..4 = next point index plus one
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         active_ff    <= 1'b0;
         reg2_ff      <= 1'b0;
         beat_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         reg2_ff      <= reg2_in;
         beat_ff      <= beat_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      br_ff   <= br_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      ox_ff   <= ox_in;
      oy_ff   <= oy_in;
      cx_ff   <= cx_in;
      cy_ff   <= cy_in;
      rad_ff  <= rad_in;
      rx2_ff  <= rx2_in;
      ry2_ff  <= ry2_in;
      d_ff    <= d_in;
      p1_ff   <= p1_in;
      acc_ff  <= acc_in;
      prod_ff <= prod_in;
      px_ff   <= px_in;
      py_ff   <= py_in;
      last_ff <= last_in;
      done_ff <= done_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_point_x     = px_ff;
   assign rsp_point_y     = py_ff;
   assign rsp_step_last   = last_ff;
   assign rsp_figure_done = done_ff;

   a_done_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_figure_done |-> rsp_step_last)
      else $error("figure_done without step_last");

   a_init_active: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_INIT |=> active_ff && !reg2_ff)
      else $error("start did not arm region 1");

   a_idle_y: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE && active_ff |-> !y_ff[CW-1])
      else $error("active walker below the axis");

   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      beat_ff != '0 |-> req_stall)
      else $error("request taken while points pending");

endmodule

>>> tb/tb_midpoint_ellipse_rasterizer.sv
// Self-checking testbench for midpoint_ellipse_rasterizer: a directed table and random
// figures driven on valid/stall, each point beat checked against an in-bench walker model or table values.
// Depends on mer_pkg and the rasteriser RTL only.
`timescale 1ns / 1ps

module tb_midpoint_ellipse_rasterizer;
   import mer_pkg::*;

   localparam int CB             = COORD_BITS_DEF;
   localparam int MAX_COORD      = (1 << CB) - 1;
   localparam int IDLE_PCT       = 38;
   localparam int RANDOM_ITEMS   = 140;
   localparam int DRAIN_CYCLES   = 40;
   localparam int WATCHDOG_LIMIT = 4000;

   localparam logic OP_START = 1'b0;
   localparam logic OP_STEP  = 1'b1;

   typedef enum logic [1:0] {
      CHK_MODEL,
      CHK_NONE,
      CHK_AXIS
   } row_check_type;

   typedef struct packed {
      logic [CB+1:0] x;
      logic [CB+1:0] y;
      logic          last;
      logic          done;
   } point_beat_type;

   typedef struct packed {
      logic          op;
      logic [CB-1:0] cx;
      logic [CB-1:0] cy;
      logic [CB-1:0] rx;
      logic [CB-1:0] ry;
      row_check_type kind;
      logic [CB+1:0] ex;
      logic [CB+1:0] ey;
   } stim_row_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   logic          req_opcode = OP_START;
   logic [CB-1:0] req_center_x = '0;
   logic [CB-1:0] req_center_y = '0;
   logic [CB-1:0] req_radius_x = '0;
   logic [CB-1:0] req_radius_y = '0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   logic signed [CB+1:0] rsp_point_x;
   logic signed [CB+1:0] rsp_point_y;
   logic          rsp_step_last;
   logic          rsp_figure_done;

   // walker model state
   bit     walk_active;
   bit     walk_region2;
   longint walk_x;
   longint walk_y;
   longint walk_d;
   longint rx_sq;
   longint ry_sq;
   longint org_x;
   longint org_y;

   point_beat_type expected_points [$];
   point_beat_type want;
   int             errors = 0;
   int             accept_count = 0;
   bit             calm = 1'b0;

   stim_row_type dir_rows [0:23] = '{
      '{OP_STEP,  1023, 1023, 1023, 1023, CHK_NONE,  0, 0},
      '{OP_START,    5,    7,    0,    0, CHK_NONE,  0, 0},
      '{OP_STEP,     0,    0,    0,    0, CHK_AXIS,  5, 7},
      '{OP_STEP,  1023,    0, 1023,    0, CHK_NONE,  0, 0},
      '{OP_START,    0,    0,    3,    2, CHK_NONE,  0, 0},
      '{OP_STEP,  1023, 1023, 1023, 1023, CHK_MODEL, 0, 0},
      '{OP_STEP,     0,    0,    0,    0, CHK_MODEL, 0, 0},
      '{OP_STEP,   341,  682,  341,  682, CHK_MODEL, 0, 0},
      '{OP_STEP,     0,    0,    0,    0, CHK_MODEL, 0, 0},
      '{OP_STEP,     0,    0,    0,    0, CHK_MODEL, 0, 0},
      '{OP_STEP,     0,    0,    0,    0, CHK_MODEL, 0, 0},
      '{OP_STEP,     0,    0,    0,    0, CHK_MODEL, 0, 0},
      '{OP_STEP,     0,    0,    0,    0, CHK_MODEL, 0, 0},
      '{OP_START, 1023, 1023, 1023, 1023, CHK_NONE,  0, 0},
      '{OP_STEP,     0,    0,    0,    0, CHK_MODEL, 0, 0},
      '{OP_STEP,     0,    0,    0,    0, CHK_MODEL, 0, 0},
      '{OP_START,    0,    0, 1023,    0, CHK_NONE,  0, 0},
      '{OP_STEP,     0,    0,    0,    0, CHK_MODEL, 0, 0},
      '{OP_START,    0, 1023,    0, 1023, CHK_NONE,  0, 0},
      '{OP_STEP,     0,    0,    0,    0, CHK_MODEL, 0, 0},
      '{OP_STEP,     0,    0,    0,    0, CHK_MODEL, 0, 0},
      '{OP_START, 1023,    0, 1023, 1023, CHK_NONE,  0, 0},
      '{OP_STEP,     0,    0,    0,    0, CHK_MODEL, 0, 0},
      '{OP_STEP,     0,    0,    0,    0, CHK_MODEL, 0, 0}
   };

   midpoint_ellipse_rasterizer #(.COORD_BITS(CB)) uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_center_x    (req_center_x),
      .req_center_y    (req_center_y),
      .req_radius_x    (req_radius_x),
      .req_radius_y    (req_radius_y),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_point_x     (rsp_point_x),
      .rsp_point_y     (rsp_point_y),
      .rsp_step_last   (rsp_step_last),
      .rsp_figure_done (rsp_figure_done)
   );

   always #6 clock = ~clock;

   // region change and end of figure
   task automatic settle_walker();
      if (!walk_region2) begin
         if (!(walk_y >= 0 && ry_sq * walk_x <= rx_sq * walk_y)) begin
            walk_d = ry_sq * (2 * walk_x + 1) * (2 * walk_x + 1)
                     + 4 * rx_sq * (walk_y - 1) * (walk_y - 1) - 4 * rx_sq * ry_sq;
            walk_region2 = 1'b1;
         end
      end
      if (walk_region2 && walk_y < 0)
         walk_active = 1'b0;
   endtask

   task automatic predict_points(input logic op, input logic [CB-1:0] cx, cy, rx, ry,
                                 output int n, output point_beat_type pts [4]);
      longint px [4];
      longint py [4];
      longint r_x;
      longint r_y;
      longint sx;
      longint sy;
      n = 0;
      for (int k = 0; k < 4; k++)
         pts[k] = '0;
      if (op == OP_START) begin
         r_x = rx;
         r_y = ry;
         org_x = cx;
         org_y = cy;
         rx_sq = r_x * r_x;
         ry_sq = r_y * r_y;
         walk_x = 0;
         walk_y = r_y;
         walk_region2 = 1'b0;
         walk_d = 4 * ry_sq - 4 * rx_sq * r_y + rx_sq;
         walk_active = 1'b1;
         settle_walker();
      end else if (walk_active) begin
         px[0] = org_x + walk_x; py[0] = org_y + walk_y;
         px[1] = org_x - walk_x; py[1] = org_y + walk_y;
         px[2] = org_x + walk_x; py[2] = org_y - walk_y;
         px[3] = org_x - walk_x; py[3] = org_y - walk_y;
         if (!walk_region2) begin
            if (walk_d < 0) begin
               walk_x++;
               walk_d += 4 * (2 * ry_sq * walk_x + ry_sq);
            end else begin
               walk_x++;
               walk_y--;
               walk_d += 4 * (2 * ry_sq * walk_x - 2 * rx_sq * walk_y + ry_sq);
            end
         end else if (walk_d > 0) begin
            walk_y--;
            walk_d -= 4 * (2 * rx_sq * walk_y + rx_sq);
         end else begin
            walk_y--;
            walk_x++;
            walk_d += 4 * (2 * ry_sq * walk_x - 2 * rx_sq * walk_y + rx_sq);
         end
         settle_walker();
         for (int k = 0; k < 4; k++) begin
            sx = px[k];
            sy = py[k];
            pts[k].x    = sx[CB+1:0];
            pts[k].y    = sy[CB+1:0];
            pts[k].last = (k == 3);
            pts[k].done = (k == 3) && !walk_active;
         end
         n = 4;
      end
   endtask

   // drive one request beat, wait for it to be taken, then queue its points
   task automatic send_beat(input logic op, input logic [CB-1:0] cx, cy, rx, ry,
                            input row_check_type kind, input logic [CB+1:0] ex, ey);
      int             n;
      point_beat_type pts [4];
      point_beat_type typed;
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_opcode   <= op;
      req_center_x <= cx;
      req_center_y <= cy;
      req_radius_x <= rx;
      req_radius_y <= ry;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      accept_count++;
      predict_points(op, cx, cy, rx, ry, n, pts);
      case (kind)
         CHK_MODEL: begin
            for (int k = 0; k < n; k++)
               expected_points.insert(expected_points.size(), pts[k]);
         end
         CHK_AXIS: begin
            for (int k = 0; k < 4; k++) begin
               typed = '{x: ex, y: ey, last: (k == 3), done: (k == 3)};
               expected_points.insert(expected_points.size(), typed);
            end
         end
         default: ;
      endcase
   endtask

   task automatic check_field(input string name, input logic [CB+1:0] exp_v, got_v);
      if (exp_v !== got_v) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d got %0d",
                  $time, name, $signed(exp_v), $signed(got_v));
      end
   endtask

   function automatic logic [CB-1:0] pick_radius();
      if ($urandom_range(99) < 15)
         return CB'($urandom_range(MAX_COORD));
      return CB'($urandom_range(12));
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         accept_count++;
         if (expected_points.size() == 0) begin
            errors++;
            $display("%0t: unexpected point beat, expected none got x=%0d y=%0d",
                     $time, rsp_point_x, rsp_point_y);
         end else begin
            want = expected_points.pop_front();
            check_field("point_x", want.x, rsp_point_x);
            check_field("point_y", want.y, rsp_point_y);
            check_field("step_last", (CB + 2)'(want.last), (CB + 2)'(rsp_step_last));
            check_field("figure_done", (CB + 2)'(want.done), (CB + 2)'(rsp_figure_done));
         end
      end
      rsp_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
   end

   initial begin : watchdog
      int last_seen;
      int quiet;
      last_seen = 0;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (accept_count != last_seen) begin
            last_seen = accept_count;
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("tb: failure");
      $finish;
   end

   initial begin : stimulus
      int            items;
      int            steps_left;
      logic [CB-1:0] rx;
      logic [CB-1:0] ry;
      items = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < $size(dir_rows); i++)
         send_beat(dir_rows[i].op, dir_rows[i].cx, dir_rows[i].cy, dir_rows[i].rx,
                   dir_rows[i].ry, dir_rows[i].kind, dir_rows[i].ex, dir_rows[i].ey);

      while (items < RANDOM_ITEMS) begin
         calm = (items >= 70 && items < 110);
         rx = pick_radius();
         ry = pick_radius();
         items++;
         send_beat(OP_START, CB'($urandom_range(MAX_COORD)), CB'($urandom_range(MAX_COORD)),
                   rx, ry, CHK_MODEL, 0, 0);
         // small figures usually run to the end, large ones are cut short by a restart
         if (rx <= 12 && ry <= 12 && $urandom_range(9) < 7)
            steps_left = 4 * MAX_COORD;
         else
            steps_left = $urandom_range(6);
         while (walk_active && steps_left > 0) begin
            items++;
            steps_left--;
            send_beat(OP_STEP, CB'($urandom_range(MAX_COORD)), CB'($urandom_range(MAX_COORD)),
                      CB'($urandom_range(MAX_COORD)), CB'($urandom_range(MAX_COORD)),
                      CHK_MODEL, 0, 0);
         end
         if (!walk_active && $urandom_range(3) == 0)
            send_beat(OP_STEP, CB'($urandom_range(MAX_COORD)), CB'($urandom_range(MAX_COORD)),
                      CB'($urandom_range(MAX_COORD)), CB'($urandom_range(MAX_COORD)),
                      CHK_MODEL, 0, 0);
      end
      calm = 1'b0;
      req_valid <= 1'b0;

      while (expected_points.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
